// ===== rtl/dcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcs_pkg
// Shared types and constants for the distributed-clock sync loop.
// ----------------------------------------------------------------------------
package dcs_pkg;

    localparam int STABLE_WINDOW = 100;
    localparam int RUN_W         = 10;

    localparam int CYCLE_W  = 31;
    localparam int THRESH_W = 30;
    localparam int SHIFT_W  = 30;
    localparam int CFG_W    = 31;
    localparam int CFG_IDX_W = 2;

    localparam int DIVIDEND_W = 64;
    localparam int NBITS_W    = 7;

    localparam logic [NBITS_W-1:0] NBITS_WIDE   = 7'd64;

    // reciprocal multipliers for the unsigned 32-bit divisions by 100 and 20
    localparam logic [31:0] ERR_RECIP = 32'h51EB_851F;
    localparam int          ERR_SHIFT = 37;
    localparam logic [31:0] INT_RECIP = 32'hCCCC_CCCD;
    localparam int          INT_SHIFT = 36;

    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT  = 2'd2;

    localparam logic [CYCLE_W-1:0]  CYCLE_RST  = 31'd1000000;
    localparam logic [THRESH_W-1:0] THRESH_RST = 30'd1000;
    localparam logic [SHIFT_W-1:0]  SHIFT_RST  = 30'd50000;

    typedef struct packed {
        logic                 start;
        logic [NBITS_W-1:0]   nbits;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

// ===== rtl/dc_clock_sync_pi_loop.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dc_clock_sync_pi_loop
// Distributed-clock phase tracking with a sign integrator and stability gate.
// ----------------------------------------------------------------------------
// One reference time word is taken per bus cycle. After a word is accepted
// s_axis_tready stays low until its result is loaded into the output
// register, so no new word is taken while one is in flight: one bit-serial
// divider does the 64-bit modulo by the cycle time, then one 32 by 32
// multiplier divides the phase error by 100 and the integrator by 20
// through reciprocal multiplication, one after the other. A finished result
// sits in the output register, so the next word is taken while it waits;
// the following result waits for that register to free up.
// Configuration writes take effect at once and belong in idle periods.
module dc_clock_sync_pi_loop
    import dcs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // ref_time[31:0], master_operational[32], zero fill
    input  logic [39:0]          s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // offset_ns[31:0], phase_error_ns[62:32], request_master_operational[63],
    // release_slaves[64], zero fill
    output logic [71:0]          m_axis_tdata
);

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_MOD, S_FOLD, S_INTEG, S_DIVE, S_DIVI, S_FIN
    } t_state;

    t_state r_state;

    logic [CYCLE_W-1:0]  r_cycle;
    logic [THRESH_W-1:0] r_thresh;
    logic [SHIFT_W-1:0]  r_shift;

    logic [31:0]      r_ref;
    logic             r_op;
    logic [31:0]      r_prev;
    logic [31:0]      r_wrap;
    logic             r_neg;
    logic [30:0]      r_err;
    logic [31:0]      r_integ;
    logic [RUN_W-1:0] r_stable_run;
    logic             r_slaves_released;
    logic             r_req;
    logic             r_rel;
    logic [31:0]      r_qe;
    logic [31:0]      r_offset;
    logic             r_out_valid;
    logic [71:0]      r_out_data;

    t_div_ctl              w_div_ctl;
    t_div_sts              w_div_sts;
    logic [DIVIDEND_W-1:0] w_dividend;
    logic [CYCLE_W-1:0]    w_rem;

    logic [31:0]           w_mul_a;
    logic [31:0]           w_mul_b;
    logic [63:0]           w_prod;
    logic [31:0]           w_quo_e;
    logic [31:0]           w_quo_i;

    logic [CYCLE_W-1:0]    w_cyc;
    logic [63:0]           w_t64;
    logic                  w_neg;
    logic [31:0]           w_ref_lo;
    logic [30:0]           w_fold;
    logic [31:0]           w_err32;
    logic [31:0]           w_thr32;
    logic                  w_inside;
    logic [31:0]           n_integ;
    logic [RUN_W-1:0]      n_stable_run;
    logic                  n_req;
    logic                  n_rel;
    logic [31:0]           w_err_mag;
    logic [31:0]           w_int_mag;
    logic [31:0]           n_offset;
    logic                  w_accept;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle  <= CYCLE_RST;
            r_thresh <= THRESH_RST;
            r_shift  <= SHIFT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CYCLE:  r_cycle  <= i_cfg_data;
                CFG_THRESH: r_thresh <= i_cfg_data[THRESH_W-1:0];
                CFG_SHIFT:  r_shift  <= i_cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_cyc    = (r_cycle == '0) ? 31'd1 : r_cycle;
    assign w_accept = s_axis_tvalid && s_axis_tready;

    // shifted extended time
    assign w_t64    = {r_wrap, r_ref};
    assign w_neg    = (r_wrap == '0) && (r_ref < {2'b00, r_shift});
    assign w_ref_lo = {2'b00, r_shift} - r_ref;

    // fold the remainder into plus or minus half a cycle; a negative shifted time gives the negated remainder
    always_comb begin
        if (r_neg) begin
            w_fold = 31'd0 - w_rem;
        end else if (w_rem > (w_cyc >> 1)) begin
            w_fold = w_rem - w_cyc;
        end else begin
            w_fold = w_rem;
        end
    end

    assign w_err32  = {r_err[30], r_err};
    assign w_thr32  = {2'b00, r_thresh};
    assign w_inside = ($signed(w_err32) < $signed(w_thr32)) &&
                      ($signed(w_err32) > -$signed(w_thr32));

    // saturating sign integrator
    always_comb begin
        n_integ = r_integ;
        if (!r_err[30] && (r_err != '0) && (r_integ != 32'h7FFF_FFFF)) begin
            n_integ = r_integ + 32'd1;
        end else if (r_err[30] && (r_integ != 32'h8000_0000)) begin
            n_integ = r_integ - 32'd1;
        end
    end

    // stability window and release
    always_comb begin
        n_stable_run = r_stable_run;
        n_req        = 1'b0;
        if (!r_op) begin
            if (w_inside) begin
                if (r_stable_run < RUN_W'(STABLE_WINDOW)) begin
                    n_stable_run = r_stable_run + 1'b1;
                end
            end else begin
                n_stable_run = '0;
            end
            n_req = (n_stable_run >= RUN_W'(STABLE_WINDOW));
        end
        n_rel = !r_slaves_released && (r_op || n_req);
    end

    assign w_err_mag = r_err[30] ? (32'd0 - w_err32) : w_err32;
    assign w_int_mag = r_integ[31] ? (32'd0 - r_integ) : r_integ;

    // shared multiplier for the divisions by 100 and 20
    assign w_mul_a = (r_state == S_DIVI) ? w_int_mag : w_err_mag;
    assign w_mul_b = (r_state == S_DIVI) ? INT_RECIP : ERR_RECIP;
    assign w_prod  = {32'd0, w_mul_a} * {32'd0, w_mul_b};
    assign w_quo_e = 32'(w_prod[63:ERR_SHIFT]);
    assign w_quo_i = 32'(w_prod[63:INT_SHIFT]);

    // offset = -(err/100) - (integral/20)
    assign n_offset = (r_err[30] ? r_qe : (32'd0 - r_qe)) +
                      (r_integ[31] ? w_quo_i : (32'd0 - w_quo_i));

    // divider request for the modulo
    always_comb begin
        w_div_ctl.start = (r_state == S_PREP);
        w_div_ctl.nbits = NBITS_WIDE;
    end

    assign w_dividend = w_neg ? {32'd0, w_ref_lo} : (w_t64 - {34'd0, r_shift});

    dcs_serial_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_div_ctl),
        .i_dividend  (w_dividend),
        .i_divisor   (w_cyc),
        .o_sts       (w_div_sts),
        .o_remainder (w_rem)
    );

    // sequencer and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_prev            <= '0;
            r_wrap            <= '0;
            r_integ           <= '0;
            r_stable_run      <= '0;
            r_slaves_released <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_ref  <= s_axis_tdata[31:0];
                        r_op   <= s_axis_tdata[32];
                        r_prev <= s_axis_tdata[31:0];
                        if (s_axis_tdata[31:0] < r_prev) begin
                            r_wrap <= r_wrap + 32'd1;
                        end
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_neg   <= w_neg;
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    if (w_div_sts.done) begin
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    r_err   <= w_fold;
                    r_state <= S_INTEG;
                end
                S_INTEG: begin
                    r_integ      <= n_integ;
                    r_stable_run <= n_stable_run;
                    r_req        <= n_req;
                    r_rel        <= n_rel;
                    if (n_rel) begin
                        r_slaves_released <= 1'b1;
                    end
                    r_state <= S_DIVE;
                end
                S_DIVE: begin
                    r_qe    <= w_quo_e;
                    r_state <= S_DIVI;
                end
                S_DIVI: begin
                    r_offset <= n_offset;
                    r_state  <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {7'd0, r_rel, r_req, r_err, r_offset};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // no new word while the divider is still working
    a_ready_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_div_sts.busy)
        else $error("input ready while divider busy");

    // divider results only arrive while the sequencer waits for them
    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_sts.done |-> (r_state == S_MOD))
        else $error("divider done in unexpected state");

    // stable run saturates at the window size
    a_run_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stable_run <= RUN_W'(STABLE_WINDOW))
        else $error("stable run beyond window");

    // release is sticky until reset
    a_release_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(r_slaves_released)) |-> r_slaves_released)
        else $error("slaves released flag cleared");

    // a release pulse leaves the sticky flag set
    a_release_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_rel) |-> r_slaves_released)
        else $error("release pulse without sticky flag");

endmodule

// ===== rtl/dcs_serial_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcs_serial_div
// Restoring divider, one quotient bit per cycle, for the modulo by the cycle
// time.
// ----------------------------------------------------------------------------
module dcs_serial_div
    import dcs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_div_ctl              i_ctl,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [CYCLE_W-1:0]    i_divisor,
    output t_div_sts              o_sts,
    output logic [CYCLE_W-1:0]    o_remainder
);

    logic [CYCLE_W-1:0]    r_rem;
    logic [DIVIDEND_W-1:0] r_dq;
    logic [CYCLE_W-1:0]    r_div;
    logic [NBITS_W-1:0]    r_cnt;
    logic                  r_done;

    logic [CYCLE_W:0]      w_trial;
    logic                  w_ge;
    logic [CYCLE_W:0]      w_diff;

    assign w_trial = {r_rem, r_dq[DIVIDEND_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_cnt <= i_ctl.nbits;
                r_rem <= '0;
                r_dq  <= i_dividend;
                r_div <= i_divisor;
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_rem  <= w_ge ? w_diff[CYCLE_W-1:0] : w_trial[CYCLE_W-1:0];
                r_dq   <= {r_dq[DIVIDEND_W-2:0], w_ge};
                r_done <= (r_cnt == 7'd1);
            end
        end
    end

    assign o_sts.busy  = (r_cnt != '0);
    assign o_sts.done  = r_done;
    assign o_remainder = r_rem;

endmodule
